### hdl/ias_pkg.sv
// Shared types and constants for the integer array sorter.
// No dependencies; compiled before every other file of the block.
package ias_pkg;

    localparam int VAL_W = 32;

    typedef logic signed [VAL_W-1:0] t_value;

    // Control that the sequencer sends to every cell of the chain.
    typedef struct packed {
        logic shift;   // move every held value one cell towards the output
    } t_cell_ctl;

endpackage

### hdl/ias_in_if.sv
// Input channel of the sorter: one value per request, with the closing mark.
// Depends on ias_pkg.
interface ias_in_if;
    import ias_pkg::*;

    logic   valid;
    logic   ready;
    t_value value;
    logic   is_last;

    modport source (output valid, output value, output is_last, input ready);
    modport sink   (input valid, input value, input is_last, output ready);
endinterface

### hdl/ias_out_if.sv
// Output channel of the sorter: sorted values with end-of-run and overflow marks.
// Depends on ias_pkg.
interface ias_out_if;
    import ias_pkg::*;

    logic   valid;
    logic   ready;
    t_value sorted_value;
    logic   end_of_run;
    logic   overflow;

    modport source (output valid, output sorted_value, output end_of_run,
                    output overflow, input ready);
    modport sink   (input valid, input sorted_value, input end_of_run,
                    input overflow, output ready);
endinterface

### hdl/ias_cell.sv
// One cell of the systolic insertion chain: holds one value and passes the
// larger of its held and incoming values to the right. Depends on ias_pkg.
module ias_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ias_pkg::t_cell_ctl i_ctl,
    input  logic               i_in_vld,
    input  ias_pkg::t_value    i_in_val,
    input  logic               i_nb_vld,
    input  ias_pkg::t_value    i_nb_val,
    output logic               o_vld,
    output ias_pkg::t_value    o_val,
    output logic               o_pass_vld,
    output ias_pkg::t_value    o_pass_val
);
    import ias_pkg::*;

    logic   r_vld, n_vld;
    t_value r_val, n_val;
    logic   r_pass_vld, n_pass_vld;
    t_value r_pass_val, n_pass_val;

    always_comb begin
        n_vld      = r_vld;
        n_val      = r_val;
        n_pass_vld = 1'b0;
        n_pass_val = r_pass_val;
        if (i_ctl.shift) begin
            n_vld = i_nb_vld;
            n_val = i_nb_val;
        end else if (i_in_vld) begin
            if (!r_vld) begin
                n_vld = 1'b1;
                n_val = i_in_val;
            end else if (i_in_val < r_val) begin
                // The newcomer takes this place and the held value moves on.
                n_val      = i_in_val;
                n_pass_vld = 1'b1;
                n_pass_val = r_val;
            end else begin
                n_pass_vld = 1'b1;
                n_pass_val = i_in_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= 1'b0;
            r_pass_vld <= 1'b0;
        end else begin
            r_vld      <= n_vld;
            r_pass_vld <= n_pass_vld;
        end
        r_val      <= n_val;
        r_pass_val <= n_pass_val;
    end

    assign o_vld      = r_vld;
    assign o_val      = r_val;
    assign o_pass_vld = r_pass_vld;
    assign o_pass_val = r_pass_val;

endmodule

### hdl/integer_array_sorter_top.sv
// Integer array sorter: a chain of insertion cells and its sequencer.
// Depends on ias_pkg, ias_in_if, ias_out_if and ias_cell.
//
// Use: values arrive on i_in, one request per cycle while i_in.ready is high.
// Each value enters the first cell of a chain of DEPTH cells; every cell keeps
// the smaller of its held and incoming values and hands the larger one to its
// right neighbour in the next cycle, so the chain stays sorted in ascending
// signed order and takes a new value every cycle.
// The request marked is_last closes the set. Values that arrive while DEPTH
// values are held are dropped, and every result of that set carries overflow.
// After the closing request the block counts down r_drain while values still
// travelling down the chain settle, then presents the held values on o_out
// from the first cell, smallest first, the last one marked end_of_run.
// Each accepted result shifts the whole chain one cell towards the output, so
// results flow at one per cycle while the receiver takes them; a stall simply
// holds the chain. i_in.ready is low from the closing request until the last
// result is taken.
// Reset (synchronous, active low) empties the chain and clears count and flag.
module integer_array_sorter_top #(
    parameter int DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ias_in_if.sink    i_in,
    ias_out_if.source o_out
);
    import ias_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_FILL,
        S_DRAIN,
        S_EMIT
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_drain;
    logic             r_drop;

    t_cell_ctl        ctl;
    logic             in_acc;
    logic             out_acc;
    logic             full;

    logic             held_vld [DEPTH];
    t_value           held_val [DEPTH];
    logic             pass_vld [DEPTH];
    t_value           pass_val [DEPTH];

    assign in_acc    = i_in.valid && i_in.ready;
    assign out_acc   = o_out.valid && o_out.ready;
    assign full      = (r_cnt == CNT_W'(DEPTH));
    assign ctl.shift = out_acc;

    assign i_in.ready         = (r_state == S_FILL);
    assign o_out.valid        = (r_state == S_EMIT);
    assign o_out.sorted_value = held_val[0];
    assign o_out.end_of_run   = (r_cnt == CNT_W'(1));
    assign o_out.overflow     = r_drop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL;
            r_cnt   <= '0;
            r_drain <= '0;
            r_drop  <= 1'b0;
        end else begin
            case (r_state)
                S_FILL: begin
                    if (in_acc) begin
                        if (full) begin
                            r_drop <= 1'b1;
                        end else begin
                            r_cnt <= r_cnt + CNT_W'(1);
                        end
                        if (i_in.is_last) begin
                            r_drain <= CNT_W'(DEPTH);
                            r_state <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN: begin
                    if (r_drain == '0) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_drain <= r_drain - CNT_W'(1);
                    end
                end
                S_EMIT: begin
                    if (out_acc) begin
                        r_cnt <= r_cnt - CNT_W'(1);
                        if (r_cnt == CNT_W'(1)) begin
                            r_drop  <= 1'b0;
                            r_state <= S_FILL;
                        end
                    end
                end
                default: begin
                    r_state <= S_FILL;
                end
            endcase
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic   in_vld;
        t_value in_val;
        logic   nb_vld;
        t_value nb_val;

        if (g == 0) begin : g_head
            assign in_vld = in_acc && !full;
            assign in_val = i_in.value;
        end else begin : g_body
            assign in_vld = pass_vld[g-1];
            assign in_val = pass_val[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign nb_vld = 1'b0;
            assign nb_val = '0;
        end else begin : g_inner
            assign nb_vld = held_vld[g+1];
            assign nb_val = held_val[g+1];
        end

        ias_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_in_vld   (in_vld),
            .i_in_val   (in_val),
            .i_nb_vld   (nb_vld),
            .i_nb_val   (nb_val),
            .o_vld      (held_vld[g]),
            .o_val      (held_val[g]),
            .o_pass_vld (pass_vld[g]),
            .o_pass_val (pass_val[g])
        );
    end

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input taken while results are being shown");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("held count beyond capacity");

    a_head_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> held_vld[0])
        else $error("result shown from an empty head cell");

    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_out.end_of_run) |=> (!o_out.valid && !held_vld[0]))
        else $error("chain not empty after the final result");

    a_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !pass_vld[DEPTH-1])
        else $error("value still moving while results are shown");
`endif

endmodule

### sim/integer_array_sorter_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of integer_array_sorter_top: random sets of signed values
// go in, and every sorted result is checked against a scoreboard that sorts on its own.
// Depends on ias_pkg, ias_in_if, ias_out_if and the sorter RTL.
module integer_array_sorter_top_test;
    import ias_pkg::*;

    localparam int DEPTH         = 16;
    localparam int RANDOM_ITEMS  = 96;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 2 * DEPTH + 16;
    localparam int LONG_HOLD     = 300;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_RHYTHM} t_rx_mode;
    typedef enum int {MIX_WIDE, MIX_NARROW, MIX_EDGES, MIX_BLEND} t_value_mix;

    typedef struct {
        t_value value;
        logic   end_of_run;
        logic   overflow;
    } t_sorted_result;

    // Keeps the open set in ascending order as requests arrive, and queues the
    // sorted results when the closing request is seen.
    class sort_scoreboard;
        t_value         held[$];
        bit             dropped;
        t_sorted_result expected[$];
        int             errors;
        int             checked;
        int             sets_closed;
        int             overflow_sets;

        function void note_request(t_value v, logic last);
            int             pos;
            t_sorted_result r;
            if (held.size() < DEPTH) begin
                // Equal values go behind the ones already held.
                pos = 0;
                while (pos < held.size() && held[pos] <= v) pos++;
                held.insert(pos, v);
            end else begin
                dropped = 1'b1;
            end
            if (last) begin
                sets_closed++;
                if (dropped) overflow_sets++;
                foreach (held[k]) begin
                    r.value      = held[k];
                    r.end_of_run = (k == held.size() - 1);
                    r.overflow   = dropped;
                    expected.push_back(r);
                end
                held.delete();
                dropped = 1'b0;
            end
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        task check_result(t_value v, logic eor, logic ovf);
            t_sorted_result want;
            if (expected.size() == 0) begin
                report($sformatf("result %0d with nothing outstanding", v));
                return;
            end
            want = expected.pop_front();
            checked++;
            if (v !== want.value)
                report($sformatf("sorted_value %0d, wanted %0d", v, want.value));
            if (eor !== want.end_of_run)
                report($sformatf("end_of_run %b, wanted %b", eor, want.end_of_run));
            if (ovf !== want.overflow)
                report($sformatf("overflow %b, wanted %b", ovf, want.overflow));
        endtask

        function int pending();
            return expected.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    ias_in_if  in_ch();
    ias_out_if out_ch();

    integer_array_sorter_top #(.DEPTH(DEPTH)) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    sort_scoreboard sb = new();

    int       requests_sent;
    int       burst_left;
    int       cycles;
    int       long_holds;
    bit       long_hold_req;
    t_rx_mode rx_mode;
    int       rx_mode_left;
    int       rx_phase;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Both channels are sampled here, before any of this edge's updates land.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready)
                sb.note_request(in_ch.value, in_ch.is_last);
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.sorted_value, out_ch.end_of_run, out_ch.overflow);
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
        $display("status: fail");
        $finish;
    end

    // Receiver: switches between random stall patterns; a requested long
    // hold-off lets the sender run into a closed input.
    initial begin
        out_ch.ready <= 1'b0;
        repeat (8) @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_req = 1'b0;
                long_holds++;
            end else begin
                if (rx_mode_left == 0) begin
                    rx_mode      = t_rx_mode'($urandom_range(0, 3));
                    rx_mode_left = $urandom_range(20, 80);
                end
                rx_mode_left--;
                rx_phase++;
                case (rx_mode)
                    RX_OPEN:   out_ch.ready <= 1'b1;
                    RX_COIN:   out_ch.ready <= $urandom_range(0, 1);
                    RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:   out_ch.ready <= (rx_phase % 3 != 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    function automatic t_value random_value(t_value_mix mix);
        t_value_mix pick;
        pick = (mix == MIX_BLEND) ? t_value_mix'($urandom_range(0, 2)) : mix;
        case (pick)
            MIX_WIDE:   return t_value'($urandom);
            MIX_NARROW: return t_value'($urandom_range(0, 6)) - 3;
            default: begin
                case ($urandom_range(0, 4))
                    0:       return 32'sh8000_0000;
                    1:       return 32'sh7fff_ffff;
                    2:       return -1;
                    3:       return 1;
                    default: return 0;
                endcase
            end
        endcase
    endfunction

    // Sender pacing: bursts of random length with idle gaps in between, and now
    // and then a long burst with no gap at all.
    task automatic pace_sender();
        if (burst_left == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
        end
        burst_left--;
    endtask

    task automatic send_value(t_value v, logic last);
        pace_sender();
        in_ch.valid   <= 1'b1;
        in_ch.value   <= v;
        in_ch.is_last <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        requests_sent++;
    endtask

    task automatic send_list(t_value vals[$]);
        foreach (vals[k]) send_value(vals[k], k == vals.size() - 1);
    endtask

    task automatic send_random_set(int n, t_value_mix mix);
        for (int k = 0; k < n; k++) send_value(random_value(mix), k == n - 1);
    endtask

    initial begin
        t_value vals[$];
        int     n;
        int     set_index;
        int     directed_count;

        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.value   <= '0;
        in_ch.is_last <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A set of one, then the extremes of the value range.
        vals = '{32'sh8000_0000};
        send_list(vals);
        vals = '{32'sh7fff_ffff, -1, 0, 1, 32'sh8000_0000};
        send_list(vals);
        // One more than the store holds, duplicates included; the closing
        // request's own value is the one dropped.
        vals.delete();
        for (int k = 0; k <= DEPTH; k++)
            vals.push_back((k % 4 == 0) ? 5 : 100 - 13 * k);
        send_list(vals);
        directed_count = requests_sent;

        set_index = 0;
        while (requests_sent < directed_count + RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: n = $urandom_range(1, 8);
                6, 7:             n = $urandom_range(9, DEPTH);
                8:                n = DEPTH;
                default:          n = $urandom_range(DEPTH + 1, DEPTH + 6);
            endcase
            if (set_index == 2) long_hold_req = 1'b1;
            send_random_set(n, t_value_mix'($urandom_range(0, 3)));
            set_index++;
        end
        in_ch.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d requests in %0d sets, %0d with dropped values",
                 requests_sent, sb.sets_closed, sb.overflow_sets);
        $display("checked %0d sorted results across %0d long receiver hold-offs",
                 sb.checked, long_holds);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
